### design/afle_pkg.sv
// shared types and constants for the addressed frame link engine
package afle_pkg;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;
  localparam logic [1:0] OP_RESPOND = 2'd3;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_PROP   = 2'd3;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_OKEY    = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [7:0] CODE_OKEY    = 8'd255;
  localparam logic [7:0] CODE_FAILED  = 8'd254;
  localparam logic [7:0] CODE_UNKNOWN = 8'd253;
  localparam logic [7:0] CODE_FETCH   = 8'd252;
  localparam logic [7:0] CODE_SET     = 8'd250;

  localparam logic [2:0] REG_OWN     = 3'd0;
  localparam logic [2:0] REG_SYNC    = 3'd1;
  localparam logic [2:0] REG_TICKS   = 3'd2;
  localparam logic [2:0] REG_TRIES   = 3'd3;
  localparam logic [2:0] REG_ENABLE  = 3'd4;

  // one result item
  typedef struct packed {
    logic       last;
    logic       pending;
    logic       is_reply;
    logic [1:0] status;
    logic [7:0] property_index;
    logic [7:0] peer_address;
    logic [7:0] value;
    logic [1:0] kind;
  } result_t;

  // what one request leaves for the emitter
  typedef struct packed {
    logic       tx;
    logic [7:0] tx_dest;
    logic [7:0] tx_data;
    logic       extra;
    result_t    extra_res;
    logic       pending;
  } plan_t;

endpackage

### design/addressed_frame_link_engine.sv
// top level of the addressed frame link engine
// the first result of an accepted request passes the plan register and then the output register
// a request yields up to 5 results, handed out one after another and held by result stalls;
// the next request is accepted as the last result is handed over, or while the emitter is idle
// the link state sits in entry 0 of a two-entry ram with registered read, the last write forwarded
// the property table is a ram cleared by a pass over all PROPERTY_COUNT entries after reset,
// during which requests are held off; rst is synchronous and active high
module addressed_frame_link_engine #(
  parameter int PROPERTY_COUNT = 256,
  parameter int VALUE_LIMIT    = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value, dest_address
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value, peer_address, property_index, status, is_reply,
                                 // pending, zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import afle_pkg::*;

  localparam int PW = (PROPERTY_COUNT > 1) ? $clog2(PROPERTY_COUNT) : 1;
  localparam int SW = 94;

  // link state word kept in memory
  typedef struct packed {
    logic [1:0]  rx_phase;
    logic [7:0]  rx_source;
    logic [7:0]  rx_destination;
    logic        awaiting_reply;
    logic [7:0]  last_receiver;
    logic [7:0]  last_sent_data;
    logic [7:0]  try_count;
    logic [15:0] elapsed_ticks;
    logic [7:0]  last_sender;
    logic [1:0]  set_phase;
    logic [7:0]  set_peer;
    logic [7:0]  set_index;
    logic [8:0]  spare;
  } link_t;

  logic [7:0]  own_address, sync_byte, max_tries;
  logic [15:0] resend_ticks;
  logic        resend_enable;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'd0;
      sync_byte <= 8'h0f;
      resend_ticks <= 16'd675;
      max_tries <= 8'd20;
      resend_enable <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN:    own_address <= cfg_data[7:0];
        REG_SYNC:   sync_byte <= cfg_data[7:0];
        REG_TICKS:  resend_ticks <= cfg_data;
        REG_TRIES:  max_tries <= cfg_data[7:0];
        REG_ENABLE: resend_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass and state initialization
  logic          clearing;
  logic [PW:0]   clr_cnt;
  logic          busy;       // emitter holds a plan
  logic          st_we;
  link_t         st_wdata, st_rdata, cur, nxt;
  logic          fwd_hit;
  link_t         fwd_word;
  logic          prop_we;
  logic [PW-1:0] prop_waddr;
  logic [7:0]    prop_wdata;
  logic [7:0]    prop_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else if (clearing) begin
      if (clr_cnt == (PW+1)'(PROPERTY_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic accept;
  assign accept = s_tvalid && s_tready;

  afle_ram #(.WIDTH(SW), .DEPTH(2)) u_state (
    .clk(clk), .we(st_we), .waddr(1'b0), .wdata(st_wdata),
    .raddr(1'b0), .rdata(st_rdata)
  );

  afle_ram #(.WIDTH(8), .DEPTH(PROPERTY_COUNT)) u_prop (
    .clk(clk), .we(prop_we), .waddr(prop_waddr), .wdata(prop_wdata),
    .raddr(prop_waddr), .rdata(prop_rdata)
  );

  // forward the word written last cycle, the ram read still shows the older one
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= st_we;
    end
    fwd_word <= st_wdata;
  end

  assign cur = fwd_hit ? fwd_word : st_rdata;

  // decode one request against the state word
  plan_t plan;
  logic  p_we;
  logic [PW-1:0] p_addr;
  always_comb begin
    logic [7:0] b, src, dst;
    logic       resp;
    logic [7:0] rdata;
    b = s_tdata[7:0];
    nxt = cur;
    plan = '0;
    p_we = 1'b0;
    p_addr = cur.set_index[PW-1:0];
    resp = 1'b0;
    rdata = CODE_OKEY;
    src = cur.rx_source;
    dst = cur.rx_destination;
    unique case (s_tuser)
      OP_RX: begin
        unique case (cur.rx_phase)
          2'd0: if (b == sync_byte) nxt.rx_phase = 2'd1;
          2'd1: begin nxt.rx_source = b; nxt.rx_phase = 2'd2; end
          2'd2: begin nxt.rx_destination = b; nxt.rx_phase = 2'd3; end
          default: begin
            nxt.rx_phase = 2'd0;
            if (dst == own_address) begin
              if (cur.set_phase != 2'd0) begin
                if (src == cur.set_peer) begin
                  nxt.last_sender = src;
                  resp = 1'b1;
                  if (cur.set_phase == 2'd1) begin
                    nxt.set_index = b;
                    nxt.set_phase = 2'd2;
                  end else begin
                    nxt.set_phase = 2'd0;
                    if (32'(cur.set_index) < PROPERTY_COUNT) begin
                      p_we = 1'b1;
                      plan.extra = 1'b1;
                      plan.extra_res.kind = KIND_PROP;
                      plan.extra_res.value = b;
                      plan.extra_res.peer_address = cur.set_peer;
                      plan.extra_res.property_index = cur.set_index;
                    end
                  end
                end
              end else begin
                nxt.last_sender = src;
                plan.extra_res.value = b;
                plan.extra_res.peer_address = src;
                if (cur.awaiting_reply && src == cur.last_receiver) begin
                  nxt.awaiting_reply = 1'b0;
                  nxt.try_count = 8'd0;
                  plan.extra = 1'b1;
                  priority if (b == CODE_OKEY) begin
                    plan.extra_res.kind = KIND_STATUS;
                    plan.extra_res.status = ST_OKEY;
                  end else if (b == CODE_FAILED) begin
                    plan.extra_res.kind = KIND_STATUS;
                    plan.extra_res.status = ST_FAILED;
                  end else if (b == CODE_UNKNOWN) begin
                    plan.extra_res.kind = KIND_STATUS;
                    plan.extra_res.status = ST_UNKNOWN;
                  end else begin
                    plan.extra_res.kind = KIND_DATA;
                    plan.extra_res.is_reply = 1'b1;
                  end
                end else if (32'(b) > VALUE_LIMIT && b == CODE_SET) begin
                  nxt.set_peer = src;
                  nxt.set_phase = 2'd1;
                  resp = 1'b1;
                end else if (!(32'(b) > VALUE_LIMIT && b == CODE_FETCH)) begin
                  plan.extra = 1'b1;
                  plan.extra_res.kind = KIND_DATA;
                end
              end
            end
          end
        endcase
      end
      OP_TICK: begin
        if (cur.elapsed_ticks != 16'hffff) nxt.elapsed_ticks = cur.elapsed_ticks + 16'd1;
        if (resend_enable && cur.awaiting_reply && nxt.elapsed_ticks >= resend_ticks &&
            cur.try_count <= max_tries) begin
          if (cur.try_count != 8'hff) nxt.try_count = cur.try_count + 8'd1;
          plan.tx = 1'b1;
          plan.tx_dest = cur.last_receiver;
          plan.tx_data = cur.last_sent_data;
          nxt.awaiting_reply = 1'b1;
        end
      end
      OP_SEND: begin
        plan.tx = 1'b1;
        plan.tx_dest = s_tdata[15:8];
        plan.tx_data = b;
        nxt.awaiting_reply = 1'b1;
      end
      default: begin
        resp = 1'b1;
        rdata = b;
      end
    endcase
    if (resp) begin
      plan.tx = 1'b1;
      plan.tx_dest = nxt.last_sender;
      plan.tx_data = rdata;
      nxt.awaiting_reply = 1'b0;
    end
    if (plan.tx) begin
      nxt.elapsed_ticks = 16'd0;
      nxt.last_receiver = plan.tx_dest;
      nxt.last_sent_data = plan.tx_data;
    end
    plan.pending = nxt.awaiting_reply;
  end

  // state write-back: reset image during clearing, decoded word on accept
  always_comb begin
    st_we = clearing || accept;
    st_wdata = clearing ? '0 : nxt;
    prop_we = clearing || (accept && p_we);
    prop_waddr = clearing ? clr_cnt[PW-1:0] : p_addr;
    prop_wdata = clearing ? 8'd0 : s_tdata[7:0];
  end

  // emitter: walks the four frame bytes and the extra result
  plan_t      pl;
  logic [2:0] step;
  logic       rvalid;
  logic [2:0] nsteps;
  logic       advance;
  logic       finishing;
  result_t    r;
  assign nsteps = (pl.tx ? 3'd4 : 3'd0) + (pl.extra ? 3'd1 : 3'd0);
  assign advance = busy && (!m_tvalid || m_tready);
  assign finishing = advance && (step == nsteps - 3'd1);

  // a new request enters as the last result of the current one is handed over
  assign s_tready = !clearing && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      pl <= plan;
      step <= 3'd0;
      busy <= plan.tx || plan.extra;
    end else if (advance) begin
      if (step == nsteps - 3'd1) busy <= 1'b0;
      step <= step + 3'd1;
    end
  end

  always_comb begin
    r = '0;
    if (pl.tx && step < 3'd4) begin
      r.kind = KIND_TX;
      unique case (step[1:0])
        2'd0: r.value = sync_byte;
        2'd1: r.value = own_address;
        2'd2: r.value = pl.tx_dest;
        default: r.value = pl.tx_data;
      endcase
    end else begin
      r = pl.extra_res;
    end
    r.pending = pl.pending;
    r.last = (step == nsteps - 3'd1);
  end

  // output register
  result_t ro;
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (!rvalid || m_tready) begin
      rvalid <= busy;
      ro <= r;
    end
  end

  assign m_tvalid = rvalid;
  assign m_tuser = ro.kind;
  assign m_tlast = ro.last;
  assign m_tdata = {4'd0, ro.pending, ro.is_reply, ro.status, ro.property_index,
                    ro.peer_address, ro.value};

  logic unused;
  assign unused = ^{prop_rdata, st_rdata.spare};
endmodule

### design/afle_ram.sv
// generic ram with one write port, one read port and registered read
module afle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### test/link_checker.sv
// watches the request, result and register channels and checks every result
module link_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);
  import afle_pkg::*;

  localparam int PROPS = 256;
  localparam logic [7:0] VALUE_LIMIT = 8'd240;

  // mirrored configuration
  logic [7:0]  own_addr, sync_val, tries_max;
  logic [15:0] ticks_max;
  logic        resend_on;

  // mirrored link state
  logic [1:0]  rx_phase;
  logic [7:0]  rx_src, rx_dst;
  logic        waiting;
  logic [7:0]  peer_last_tx, data_last_tx, tries, sender_last;
  logic [15:0] elapsed;
  logic [1:0]  set_phase;
  logic [7:0]  set_peer, set_idx;
  logic [7:0]  props [PROPS];

  result_t expected_results[$];
  result_t step_results[$];

  assign outstanding = expected_results.size();

  function automatic result_t make_res(logic [1:0] k, logic [7:0] v, logic [7:0] p,
                                       logic [7:0] idx, logic [1:0] st, logic rep);
    result_t r;
    r = '0;
    r.kind = k;
    r.value = v;
    r.peer_address = p;
    r.property_index = idx;
    r.status = st;
    r.is_reply = rep;
    return r;
  endfunction

  task automatic send_frame(logic [7:0] dest, logic [7:0] data);
    waiting = 1'b1;
    elapsed = '0;
    peer_last_tx = dest;
    data_last_tx = data;
    step_results.push_back(make_res(KIND_TX, sync_val, 8'd0, 8'd0, ST_NONE, 1'b0));
    step_results.push_back(make_res(KIND_TX, own_addr, 8'd0, 8'd0, ST_NONE, 1'b0));
    step_results.push_back(make_res(KIND_TX, dest, 8'd0, 8'd0, ST_NONE, 1'b0));
    step_results.push_back(make_res(KIND_TX, data, 8'd0, 8'd0, ST_NONE, 1'b0));
  endtask

  task automatic answer_sender(logic [7:0] data);
    send_frame(sender_last, data);
    waiting = 1'b0;
  endtask

  task automatic take_frame(logic [7:0] src, logic [7:0] dst, logic [7:0] data);
    if (dst != own_addr) return;
    // an open set exchange owns frames from its peer
    if (set_phase != 2'd0) begin
      if (src != set_peer) return;
      sender_last = src;
      if (set_phase == 2'd1) begin
        set_idx = data;
        answer_sender(CODE_OKEY);
        set_phase = 2'd2;
      end else begin
        answer_sender(CODE_OKEY);
        set_phase = 2'd0;
        props[set_idx] = data;
        step_results.push_back(make_res(KIND_PROP, data, set_peer, set_idx, ST_NONE, 1'b0));
      end
      return;
    end
    sender_last = src;
    // reply to the pending send
    if (waiting && src == peer_last_tx) begin
      waiting = 1'b0;
      tries = '0;
      case (data)
        CODE_OKEY:
          step_results.push_back(make_res(KIND_STATUS, data, src, 8'd0, ST_OKEY, 1'b0));
        CODE_FAILED:
          step_results.push_back(make_res(KIND_STATUS, data, src, 8'd0, ST_FAILED, 1'b0));
        CODE_UNKNOWN:
          step_results.push_back(make_res(KIND_STATUS, data, src, 8'd0, ST_UNKNOWN, 1'b0));
        default:
          step_results.push_back(make_res(KIND_DATA, data, src, 8'd0, ST_NONE, 1'b1));
      endcase
      return;
    end
    if (data > VALUE_LIMIT) begin
      if (data == CODE_SET) begin
        set_peer = src;
        answer_sender(CODE_OKEY);
        set_phase = 2'd1;
        return;
      end
      if (data == CODE_FETCH) return;
    end
    step_results.push_back(make_res(KIND_DATA, data, src, 8'd0, ST_NONE, 1'b0));
  endtask

  task automatic predict_request(logic [1:0] op, logic [7:0] b, logic [7:0] dest);
    step_results = {};
    case (op)
      OP_RX: begin
        case (rx_phase)
          2'd0: if (b == sync_val) rx_phase = 2'd1;
          2'd1: begin rx_src = b; rx_phase = 2'd2; end
          2'd2: begin rx_dst = b; rx_phase = 2'd3; end
          default: begin
            rx_phase = 2'd0;
            take_frame(rx_src, rx_dst, b);
          end
        endcase
      end
      OP_TICK: begin
        if (elapsed != 16'hffff) elapsed++;
        if (resend_on && waiting && elapsed >= ticks_max && tries <= tries_max) begin
          if (tries != 8'hff) tries++;
          send_frame(peer_last_tx, data_last_tx);
        end
      end
      OP_SEND: send_frame(dest, b);
      default: answer_sender(b);
    endcase
    foreach (step_results[k]) begin
      step_results[k].pending = waiting;
      step_results[k].last = (k == step_results.size() - 1);
      expected_results.push_back(step_results[k]);
    end
  endtask

  // track state, predict on each request, compare each result
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      own_addr <= 8'd0; sync_val <= 8'h0f; ticks_max <= 16'd675;
      tries_max <= 8'd20; resend_on <= 1'b1;
      rx_phase = '0; rx_src = '0; rx_dst = '0; waiting = 1'b0; peer_last_tx = '0;
      data_last_tx = '0; tries = '0; elapsed = '0; sender_last = '0;
      set_phase = '0; set_peer = '0; set_idx = '0;
      foreach (props[i]) props[i] = 8'd0;
      expected_results = {};
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OWN:    own_addr <= cfg_data[7:0];
          REG_SYNC:   sync_val <= cfg_data[7:0];
          REG_TICKS:  ticks_max <= cfg_data;
          REG_TRIES:  tries_max <= cfg_data[7:0];
          REG_ENABLE: resend_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[27:0], m_tuser};
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_tdata[31:28] !== 4'b0000) begin
            if (errors < 10)
              $display("mismatch: expected %h got %h (tdata %h)", want, got, m_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### test/testbench.sv
// stimulus and verdict for the addressed frame link engine
module testbench;
  import afle_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors, outstanding;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [7:0]  own_addr = 8'd0, sync_val = 8'h0f;

  always #10 clk = ~clk;

  addressed_frame_link_engine dut (.*);
  link_checker watch (.*);

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n - 1) @(negedge clk);
      end else m_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OWN) own_addr = val[7:0];
    if (idx == REG_SYNC) sync_val = val[7:0];
  endtask

  // one request, with an optional random gap before it; valid stays up after the
  // accepting edge so that the next request can follow without a gap
  task automatic request(logic [1:0] op, logic [7:0] b, logic [7:0] dest);
    int n;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1; s_tuser <= op; s_tdata <= {dest, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic frame_in(logic [7:0] src, logic [7:0] dst, logic [7:0] data);
    request(OP_RX, sync_val, 8'd0);
    request(OP_RX, src, 8'd0);
    request(OP_RX, dst, 8'd0);
    request(OP_RX, data, 8'd0);
  endtask

  // drop valid after the last request and wait for every result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 5))
      0: return 8'd250;
      1: return 8'd252;
      2: return 8'($urandom_range(253, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random phase with a mix of well-formed traffic and noise
  task automatic random_phase(int count, logic [7:0] peer);
    int i;
    logic [7:0] src;
    i = 0;
    while (i < count) begin
      src = ($urandom_range(0, 3) != 0) ? peer : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          frame_in(src, ($urandom_range(0, 5) != 0) ? own_addr : 8'($urandom_range(0, 255)),
                   rand_data());
          i += 4;
        end
        3: begin
          frame_in(src, own_addr, 8'd250);
          frame_in(src, own_addr, 8'($urandom_range(0, 255)));
          frame_in(src, own_addr, 8'($urandom_range(0, 255)));
          i += 12;
        end
        4: begin request(OP_SEND, rand_data(), peer); i++; end
        5: begin request(OP_RESPOND, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))); i++; end
        6, 7: begin request(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))); i++; end
        default: begin request(OP_RX, 8'($urandom_range(0, 255)), 8'd0); i++; end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset configuration, send, reply codes, set exchange
    request(OP_RX, 8'h33, 8'd0);
    request(OP_SEND, 8'h00, 8'hff);
    frame_in(8'hff, 8'd0, CODE_OKEY);
    request(OP_SEND, 8'hff, 8'd7);
    frame_in(8'd7, 8'd0, CODE_FAILED);
    request(OP_SEND, 8'd1, 8'd7);
    frame_in(8'd7, 8'd0, CODE_UNKNOWN);
    frame_in(8'd9, 8'd1, 8'd5);
    frame_in(8'd9, 8'd0, CODE_FETCH);
    frame_in(8'd9, 8'd0, 8'd251);
    frame_in(8'd9, 8'd0, CODE_SET);
    frame_in(8'd8, 8'd0, 8'd3);
    frame_in(8'd9, 8'd0, 8'd255);
    frame_in(8'd9, 8'd0, 8'd170);
    request(OP_RESPOND, 8'h55, 8'h00);
    drain();

    // resend timeout with small limits
    write_reg(REG_TICKS, 16'd0);
    write_reg(REG_TRIES, 16'd1);
    write_reg(REG_ENABLE, 16'd1);
    request(OP_SEND, 8'h42, 8'd3);
    repeat (4) request(OP_TICK, 8'd0, 8'd0);
    drain();

    // random phases across several settings
    write_reg(REG_OWN, 16'd255); write_reg(REG_SYNC, 16'd0);
    write_reg(REG_TICKS, 16'd2); write_reg(REG_TRIES, 16'd255);
    random_phase(50, 8'd0);
    drain();
    write_reg(REG_OWN, 16'd90); write_reg(REG_SYNC, 16'd255);
    write_reg(REG_TICKS, 16'd65535); write_reg(REG_TRIES, 16'd0);
    write_reg(REG_ENABLE, 16'd0);
    random_phase(50, 8'd255);
    drain();
    write_reg(REG_OWN, 16'd17); write_reg(REG_SYNC, 16'h5a);
    write_reg(REG_TICKS, 16'd1); write_reg(REG_TRIES, 16'd3);
    write_reg(REG_ENABLE, 16'd1);
    random_phase(35, 8'd44);
    calm = 1'b1;
    random_phase(25, 8'd44);
    drain();

    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
